// ===== hdl/prbpm_pkg.sv =====
package prbpm_pkg;

	localparam int PAGE_BYTES  = 4096;
	localparam int MAX_PAGES   = 16;
	localparam int BATCH_RESET = 1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [4:0] PAGES_RESET = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_THRESHOLD = 1'b1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic load;
		logic rd;
		logic pad;
		logic place;
		logic refuse;
	} prbpm_cmd_t;

	typedef struct packed {
		logic is_read;
		logic fits;
		logic crosses;
	} prbpm_stat_t;

endpackage

// ===== hdl/prbpm_ctrl.sv =====
module prbpm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  prbpm_pkg::prbpm_stat_t stat,
	output prbpm_pkg::prbpm_cmd_t  cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RECHECK
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				priority if (stat.is_read) begin
					cmd.rd    = 1'b1;
					state_nxt = ST_IDLE;
				end else if (!stat.fits) begin
					cmd.refuse = 1'b1;
					state_nxt  = ST_IDLE;
				end else if (stat.crosses) begin
					cmd.pad   = 1'b1;
					state_nxt = ST_RECHECK;
				end else begin
					cmd.place = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_RECHECK: begin
				if (stat.fits) begin
					cmd.place = 1'b1;
				end else begin
					cmd.refuse = 1'b1;
				end
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.rd | cmd.place | cmd.refuse;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/prbpm_datapath.sv =====
module prbpm_datapath #(
	parameter int PAGE_BYTES = prbpm_pkg::PAGE_BYTES,
	parameter int MAX_PAGES  = prbpm_pkg::MAX_PAGES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  prbpm_pkg::prbpm_cmd_t                cmd,
	output prbpm_pkg::prbpm_stat_t               stat,
	input  logic                                 op,
	input  logic [12:0]                          record_bytes,
	input  logic [15:0]                          consumed_items,
	input  logic [15:0]                          consumed_bytes,
	input  logic                                 cfg_we,
	input  logic [prbpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prbpm_pkg::CFG_DAT_W-1:0]      cfg_data,
	output logic                                 accepted,
	output logic [15:0]                          record_offset,
	output logic                                 padded,
	output logic [15:0]                          pad_offset,
	output logic [15:0]                          fill_bytes,
	output logic                                 batch_ready
);

	localparam int PAGE_LOG = $clog2(PAGE_BYTES);
	localparam int PTR_W    = PAGE_LOG + $clog2(MAX_PAGES);
	localparam int CW       = ((PTR_W > 16) ? PTR_W : 16) + 1;
	localparam logic [10:0]      MAXP      = 11'(MAX_PAGES);
	localparam logic [PTR_W-1:0] PAGE_SZ   = PTR_W'(PAGE_BYTES);
	localparam logic [PTR_W-1:0] PAGE_MASK = PTR_W'(PAGE_BYTES - 1);
	localparam logic [CW-1:0]    PAGE_CW   = CW'(PAGE_BYTES);

	logic [4:0]       pages_q;
	logic [15:0]      thr_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [15:0]      cnt_q;

	logic             op_q;
	logic [12:0]      len_q;
	logic [15:0]      items_q;
	logic [15:0]      bytes_q;

	logic             acc_q;
	logic [15:0]      rec_off_q;
	logic             pad_q;
	logic [15:0]      pad_off_q;
	logic [15:0]      fill_q;
	logic             ready_q;

	logic [10:0]      n_cl;
	logic [3:0]       plog;
	logic [PTR_W:0]   mask_w;
	logic [PTR_W-1:0] mask;

	logic [PTR_W-1:0] head;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] space;
	logic [PTR_W-1:0] next_page;
	logic [PTR_W-1:0] placed_head;
	logic [PTR_W-1:0] fill_now;
	logic [PTR_W-1:0] new_tail;
	logic [CW-1:0]    room;
	logic [15:0]      cnt_inc;
	logic [15:0]      cnt_dec;

	always_comb begin
		n_cl = 11'(pages_q);
		if (n_cl > MAXP) begin
			n_cl = MAXP;
		end
		if (n_cl == 11'd0) begin
			n_cl = 11'd1;
		end
		plog = 4'd0;
		for (int i = 0; i < 11; i++) begin
			if (n_cl[i]) begin
				plog = 4'(i);
			end
		end
		mask_w = ((PTR_W+1)'(1) << (5'(PAGE_LOG) + 5'(plog))) - (PTR_W+1)'(1);
		mask   = mask_w[PTR_W-1:0];
	end

	assign head        = wp_q & mask;
	assign tail        = rp_q & mask;
	assign space       = (tail - head - PTR_W'(1)) & mask;
	assign room        = PAGE_CW - CW'(head & PAGE_MASK);
	assign next_page   = ((head & ~PAGE_MASK) + PAGE_SZ) & mask;
	assign placed_head = (head + PTR_W'(len_q)) & mask;
	assign fill_now    = (head - tail) & mask;
	assign new_tail    = (CW'(bytes_q) > CW'(fill_now)) ? head
	                   : ((tail + PTR_W'(bytes_q)) & mask);
	assign cnt_inc     = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	assign cnt_dec     = (items_q > cnt_q) ? 16'd0 : cnt_q - items_q;

	assign stat.is_read = (op_q == prbpm_pkg::OP_READ);
	assign stat.fits    = (CW'(len_q) <= CW'(space));
	assign stat.crosses = (CW'(len_q) > room);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= prbpm_pkg::PAGES_RESET;
			thr_q   <= 16'(prbpm_pkg::BATCH_RESET);
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					prbpm_pkg::REG_PAGES_IN_USE:    pages_q <= cfg_data[4:0];
					prbpm_pkg::REG_BATCH_THRESHOLD: thr_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.pad) begin
				wp_q <= next_page;
			end
			if (cmd.place) begin
				wp_q  <= placed_head;
				cnt_q <= cnt_inc;
			end
			if (cmd.rd) begin
				rp_q  <= new_tail;
				cnt_q <= cnt_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			len_q     <= record_bytes;
			items_q   <= consumed_items;
			bytes_q   <= consumed_bytes;
			pad_q     <= 1'b0;
			pad_off_q <= '0;
		end
		if (cmd.pad) begin
			pad_q     <= 1'b1;
			pad_off_q <= 16'(head);
		end
		if (cmd.place) begin
			acc_q     <= 1'b1;
			rec_off_q <= 16'(head);
			fill_q    <= 16'((placed_head - tail) & mask);
			ready_q   <= (cnt_inc >= thr_q);
		end
		if (cmd.refuse) begin
			acc_q     <= 1'b0;
			rec_off_q <= '0;
			fill_q    <= 16'(fill_now);
			ready_q   <= 1'b0;
		end
		if (cmd.rd) begin
			acc_q     <= 1'b1;
			rec_off_q <= '0;
			fill_q    <= 16'((head - new_tail) & mask);
			ready_q   <= 1'b0;
		end
	end

	assign accepted      = acc_q;
	assign record_offset = rec_off_q;
	assign padded        = pad_q;
	assign pad_offset    = pad_off_q;
	assign fill_bytes    = fill_q;
	assign batch_ready   = ready_q;

endmodule

// ===== hdl/paged_ring_buffer_pointer_manager.sv =====
// done is registered from the final command, in ST_EVAL or, after a pad, in ST_RECHECK.
// start is taken only in ST_IDLE, so a new word waits while busy; the space check
// and the pad move share one pointer datapath, stepped by the controller.
// done is high for one cycle and the results are valid with it; the receiver cannot stall.
// Reset: head, tail and item count clear; pages_in_use resets to 16, batch_threshold to 1.
module paged_ring_buffer_pointer_manager #(
	parameter int PAGE_BYTES = prbpm_pkg::PAGE_BYTES,
	parameter int MAX_PAGES  = prbpm_pkg::MAX_PAGES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [12:0]                      record_bytes,
	input  logic [15:0]                      consumed_items,
	input  logic [15:0]                      consumed_bytes,
	output logic                             done,
	output logic                             accepted,
	output logic [15:0]                      record_offset,
	output logic                             padded,
	output logic [15:0]                      pad_offset,
	output logic [15:0]                      fill_bytes,
	output logic                             batch_ready,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [prbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prbpm_pkg::CFG_DAT_W-1:0]  cfg_data
);

	prbpm_pkg::prbpm_cmd_t  cmd;
	prbpm_pkg::prbpm_stat_t stat;

	assign cfg_ready = 1'b1;

	prbpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	prbpm_datapath #(
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_PAGES  (MAX_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (op),
		.record_bytes   (record_bytes),
		.consumed_items (consumed_items),
		.consumed_bytes (consumed_bytes),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accepted       (accepted),
		.record_offset  (record_offset),
		.padded         (padded),
		.pad_offset     (pad_offset),
		.fill_bytes     (fill_bytes),
		.batch_ready    (batch_ready)
	);

endmodule

// ===== hdl/prbpm_checker.sv =====
module prbpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        accepted,
	input logic [15:0] record_offset,
	input logic        padded,
	input logic [15:0] pad_offset,
	input logic        batch_ready
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("start not followed by busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted |-> record_offset == 16'd0 && !batch_ready)
		else $error("refused word carries offset or batch flag");

	a_pad_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done && !padded |-> pad_offset == 16'd0)
		else $error("pad offset without padding");

endmodule

bind paged_ring_buffer_pointer_manager prbpm_checker u_prbpm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.accepted      (accepted),
	.record_offset (record_offset),
	.padded        (padded),
	.pad_offset    (pad_offset),
	.batch_ready   (batch_ready)
);

// ===== bench/paged_ring_buffer_pointer_manager_tb.sv =====
module paged_ring_buffer_pointer_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_BYTES   = prbpm_pkg::PAGE_BYTES;
	localparam int MAX_PAGES    = prbpm_pkg::MAX_PAGES;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_WORDS = 1350;
	localparam int PHASES       = 12;

	localparam logic [15:0] PAGE_CHOICES [PHASES] = '{
		16'd1, 16'd2, 16'd4, 16'd0, 16'd3, 16'd8,
		16'hFFE2, 16'd31, 16'd17, 16'd1, 16'd2, 16'd16
	};

	typedef struct packed {
		logic        accepted;
		logic [15:0] record_offset;
		logic        padded;
		logic [15:0] pad_offset;
		logic [15:0] fill_bytes;
		logic        batch_ready;
	} ring_result_t;

	logic                            clk            = 1'b0;
	logic                            arst_n         = 1'b0;
	logic                            start          = 1'b0;
	logic                            busy;
	logic                            op             = prbpm_pkg::OP_WRITE;
	logic [12:0]                     record_bytes   = '0;
	logic [15:0]                     consumed_items = '0;
	logic [15:0]                     consumed_bytes = '0;
	logic                            done;
	logic                            accepted;
	logic [15:0]                     record_offset;
	logic                            padded;
	logic [15:0]                     pad_offset;
	logic [15:0]                     fill_bytes;
	logic                            batch_ready;
	logic                            cfg_valid      = 1'b0;
	logic                            cfg_ready;
	logic [prbpm_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
	logic [prbpm_pkg::CFG_DAT_W-1:0] cfg_data       = '0;

	int unsigned head_ptr   = 0;
	int unsigned tail_ptr   = 0;
	int unsigned item_cnt   = 0;
	logic [4:0]  pages_cfg  = prbpm_pkg::PAGES_RESET;
	logic [15:0] thresh_cfg = 16'(prbpm_pkg::BATCH_RESET);

	ring_result_t pending_q [$];
	ring_result_t seen_word;
	ring_result_t due_word;

	int unsigned mismatches     = 0;
	int unsigned words_sent     = 0;
	int unsigned writes_placed  = 0;
	int unsigned writes_refused = 0;
	int unsigned pads_taken     = 0;
	int unsigned reads_done     = 0;
	int unsigned settings_used  = 0;
	int unsigned cycle_cnt      = 0;

	paged_ring_buffer_pointer_manager dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned ring_mask();
		int unsigned n;
		int unsigned p;
		n = 32'(pages_cfg);
		p = 1;
		if (n > MAX_PAGES) n = MAX_PAGES;
		if (n == 0) n = 1;
		while (p * 2 <= n) p = p * 2;
		return p * PAGE_BYTES - 1;
	endfunction

	function automatic int unsigned ring_fill();
		return ((head_ptr & ring_mask()) - (tail_ptr & ring_mask())) & ring_mask();
	endfunction

	function automatic int unsigned ring_space();
		return ((tail_ptr & ring_mask()) - ((head_ptr & ring_mask()) + 1)) & ring_mask();
	endfunction

	function automatic ring_result_t ring_step(logic word_op, int unsigned len,
		int unsigned items, int unsigned nbytes);
		int unsigned  mask;
		int unsigned  head;
		int unsigned  tail;
		int unsigned  space;
		int unsigned  page_off;
		ring_result_t r;
		mask = ring_mask();
		head = head_ptr & mask;
		tail = tail_ptr & mask;
		r = '0;
		if (word_op == prbpm_pkg::OP_WRITE) begin
			space = (tail - (head + 1)) & mask;
			if (len <= space) begin
				page_off = head & (PAGE_BYTES - 1);
				r.accepted = 1'b1;
				if (len > PAGE_BYTES - page_off) begin
					r.padded = 1'b1;
					r.pad_offset = 16'(head);
					head = ((head & ~(PAGE_BYTES - 1)) + PAGE_BYTES) & mask;
					space = (tail - (head + 1)) & mask;
					if (len > space) r.accepted = 1'b0;
				end
				if (r.accepted) begin
					r.record_offset = 16'(head);
					head = (head + len) & mask;
					if (item_cnt < 16'hFFFF) item_cnt++;
					r.batch_ready = (item_cnt >= thresh_cfg);
				end
			end
		end else begin
			r.accepted = 1'b1;
			if (nbytes > ((head - tail) & mask)) tail = head;
			else tail = (tail + nbytes) & mask;
			if (items > item_cnt) item_cnt = 0;
			else item_cnt -= items;
		end
		head_ptr = head;
		tail_ptr = tail;
		r.fill_bytes = 16'((head - tail) & mask);
		return r;
	endfunction

	task automatic report_mismatch(string tag, ring_result_t want, ring_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch (%s) at cycle %0d", tag, cycle_cnt);
			$display("  expected acc=%0b rec=%h pad=%0b pad_off=%h fill=%h batch=%0b",
				want.accepted, want.record_offset, want.padded, want.pad_offset,
				want.fill_bytes, want.batch_ready);
			$display("  actual   acc=%0b rec=%h pad=%0b pad_off=%h fill=%h batch=%0b",
				got.accepted, got.record_offset, got.padded, got.pad_offset,
				got.fill_bytes, got.batch_ready);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_word = {accepted, record_offset, padded, pad_offset, fill_bytes, batch_ready};
			if (pending_q.size() == 0) begin
				report_mismatch("result with no word pending", '0, seen_word);
			end else begin
				due_word = pending_q.pop_front();
				if (seen_word.accepted !== due_word.accepted ||
					seen_word.record_offset !== due_word.record_offset ||
					seen_word.padded !== due_word.padded ||
					seen_word.pad_offset !== due_word.pad_offset ||
					seen_word.fill_bytes !== due_word.fill_bytes ||
					seen_word.batch_ready !== due_word.batch_ready) begin
					report_mismatch("wrong field", due_word, seen_word);
				end
			end
		end
	end

	task automatic send_word(logic word_op, logic [12:0] nbytes, logic [15:0] items,
		logic [15:0] cbytes);
		ring_result_t r;
		start <= 1'b1;
		op <= word_op;
		record_bytes <= nbytes;
		consumed_items <= items;
		consumed_bytes <= cbytes;
		do @(posedge clk); while (busy);
		r = ring_step(word_op, 32'(nbytes), 32'(items), 32'(cbytes));
		pending_q.push_back(r);
		words_sent++;
		if (word_op == prbpm_pkg::OP_READ) reads_done++;
		else if (r.accepted) writes_placed++;
		else writes_refused++;
		if (r.padded) pads_taken++;
	endtask

	task automatic write_rec(logic [12:0] len);
		send_word(prbpm_pkg::OP_WRITE, len, 16'($urandom), 16'($urandom));
	endtask

	task automatic read_back(logic [15:0] items, logic [15:0] nbytes);
		send_word(prbpm_pkg::OP_READ, 13'($urandom), items, nbytes);
	endtask

	task automatic idle_gap(bit allow);
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (!allow || pick < 55) n = 0;
		else if (pick < 90) n = $urandom_range(3, 1);
		else n = $urandom_range(40, 4);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [prbpm_pkg::CFG_IDX_W-1:0] idx,
		logic [prbpm_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == prbpm_pkg::REG_PAGES_IN_USE) pages_cfg = data[4:0];
		else thresh_cfg = data;
	endtask

	task automatic set_ring(logic [15:0] pages, logic [15:0] thresh);
		wait_idle();
		write_reg(prbpm_pkg::REG_PAGES_IN_USE, pages);
		write_reg(prbpm_pkg::REG_BATCH_THRESHOLD, thresh);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_word();
		int unsigned pick;
		int unsigned room;
		logic [15:0] items;
		pick = $urandom_range(99);
		if (pick < 65) begin
			pick = $urandom_range(99);
			room = PAGE_BYTES - (head_ptr & ring_mask() & (PAGE_BYTES - 1));
			if (pick < 55) write_rec(13'($urandom_range(256, 1)));
			else if (pick < 78) write_rec(13'($urandom_range(PAGE_BYTES, 257)));
			else if (pick < 86) write_rec(13'(room - 1 + $urandom_range(2)));
			else if (pick < 92) write_rec(13'(ring_space() + $urandom_range(1)));
			else write_rec(13'($urandom));
		end else begin
			items = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
			pick = $urandom_range(99);
			if (pick < 40) read_back(items, 16'($urandom_range(ring_fill())));
			else if (pick < 65) read_back(items, 16'($urandom_range(64)));
			else if (pick < 85) read_back(items, 16'(ring_fill() + $urandom_range(1)));
			else read_back(16'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_reset_config();
		write_rec(13'd0);
		idle_gap(1'b1);
		write_rec(13'd1);
		idle_gap(1'b1);
		write_rec(13'(PAGE_BYTES));
		idle_gap(1'b1);
		write_rec(13'h1FFF);
		idle_gap(1'b1);
		read_back(16'd0, 16'd0);
		idle_gap(1'b1);
		read_back(16'd1, 16'd100);
		idle_gap(1'b1);
		read_back(16'hFFFF, 16'hFFFF);
		idle_gap(1'b1);
	endtask

	task automatic test_one_page_ring();
		int unsigned at;
		set_ring(16'd1, 16'd0);
		read_back(16'hFFFF, 16'hFFFF);
		at = head_ptr & ring_mask();
		if (at != 0) write_rec(13'(PAGE_BYTES - at));
		read_back(16'd0, 16'hFFFF);
		idle_gap(1'b1);
		write_rec(13'(PAGE_BYTES));
		write_rec(13'(PAGE_BYTES - 1));
		idle_gap(1'b1);
		write_rec(13'd1);
		read_back(16'd0, 16'd100);
		// pad at the ring end, then the same record no longer fits
		write_rec(13'd100);
		idle_gap(1'b1);
		write_rec(13'd99);
		write_rec(13'd1);
		read_back(16'hFFFF, 16'd50);
		write_rec(13'd50);
		idle_gap(1'b1);
	endtask

	task automatic test_random_traffic();
		logic [15:0] thresh;
		bit          gaps_on;
		for (int i = 0; i < PHASES; i++) begin
			case (i % 6)
				0: thresh = 16'd0;
				1: thresh = 16'd1;
				2: thresh = 16'hFFFF;
				3: thresh = 16'($urandom_range(8, 2));
				default: thresh = 16'($urandom);
			endcase
			set_ring(PAGE_CHOICES[i], thresh);
			gaps_on = (i % 3 != 1);
			repeat (RANDOM_WORDS / PHASES) begin
				random_word();
				if ($urandom_range(99) == 0) wait_idle();
				else idle_gap(gaps_on);
			end
		end
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			pending_q.size());
		$display("paged_ring_buffer_pointer_manager_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_one_page_ring();
		test_random_traffic();
		wait_idle();
		$display("covered %0d words: %0d writes placed, %0d refused, %0d page pads, %0d reads",
			words_sent, writes_placed, writes_refused, pads_taken, reads_done);
		$display("over %0d ring settings incl. odd page counts; %0d mismatches",
			settings_used, mismatches);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("paged_ring_buffer_pointer_manager_tb OK");
		end else begin
			$display("paged_ring_buffer_pointer_manager_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/prbpm_pkg.sv
hdl/prbpm_ctrl.sv
hdl/prbpm_datapath.sv
hdl/paged_ring_buffer_pointer_manager.sv
hdl/prbpm_checker.sv
bench/paged_ring_buffer_pointer_manager_tb.sv
